@@ rtl/assert_macros.svh @@
// Assertion macros shared by the camera view matrix RTL.
// Included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CVM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CVM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/cvm_pkg.sv @@
// Types, constants and helper functions of the camera view matrix unit.
// Used by camera_view_matrix_unit and cvm_normalize; depends on nothing else.
package cvm_pkg;

  typedef struct packed {
    logic        [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] side_x;
    logic signed [15:0] side_y;
    logic signed [15:0] side_z;
    logic signed [15:0] upv_x;
    logic signed [15:0] upv_y;
    logic signed [15:0] upv_z;
    logic signed [15:0] back_x;
    logic signed [15:0] back_y;
    logic signed [15:0] back_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } view_t;

  typedef enum logic [1:0] {
    REG_UP_X = 2'd0,
    REG_UP_Y = 2'd1,
    REG_UP_Z = 2'd2
  } cfg_reg_t;

  localparam int ONE_Q14 = 16384;
  localparam int SIN_A   = 25736;
  localparam int SIN_B   = 10512;
  localparam int SIN_C   = 1160;

  // Root width of the square root chain, numerator width of the divider,
  // quotient width and component width of a normalizer input vector.
  localparam int ROOT_W = 31;
  localparam int NUM_W  = 47;
  localparam int QUO_W  = 15;
  localparam int VEC_W  = 32;

  // Data carried down the main pipeline. Each stage fills in its own fields, but the two polynomial steps both write r.
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [3:0][14:0] z;
    logic [3:0]       neg;
    logic [3:0][14:0] z2;
    logic [3:0][14:0] r;
    logic [3:0][15:0] sn;
    logic [2:0][15:0] raw;
    logic [2:0][28:0] sqp;
    logic [29:0]      sq1;
    logic [2:0][15:0] f;
    logic [2:0][31:0] c;
    logic [2:0][60:0] csq;
    logic [61:0]      sq2;
    logic [2:0][15:0] s;
    logic [5:0][31:0] xp;
    logic [2:0][15:0] u;
    logic [8:0][47:0] tp;
    logic [2:0][49:0] tsum;
  } work_t;

  // Shift right by 14 with rounding half away from zero.
  function automatic logic signed [63:0] round14(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] rq;
    mag = v[63] ? 64'(-v) : 64'(v);
    rq  = (mag + 64'd8192) >> 14;
    return v[63] ? -$signed(rq) : $signed(rq);
  endfunction

endpackage

@@ rtl/camera_view_matrix_unit.sv @@
// Camera view matrix unit: look-at rotation rows and translation from a pose.
// Depends on cvm_pkg, cvm_normalize and assert_macros.svh.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 up_x, 1 up_y,
//   2 up_z) and cfg_data, Q1.14. cfg_ready is always high; write only while
//   no pose is in flight. Other indexes are ignored.
//   Input: pose_valid/pose_ready carrying yaw, pitch and a Q16.16 position.
//   Output: view_valid/view_ready carrying the side, up and back rows and
//   the saturated translation.
// Timing:
//   One pose is taken per cycle while the pipeline is not stalled. The
//   pipeline depth is set by the two normalizers, each a chain of
//   31 square root cells, a setup register and 15 divider cells, plus the
//   sine, cross product and dot product stages around them.
// Stall and reset:
//   The whole pipeline advances together; while the output register holds a
//   result that is not taken, pose_ready is low and every stage holds.
//   Reset clears all valid flags and loads up = (0, 1, 0).
`include "assert_macros.svh"

module camera_view_matrix_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  input  logic            pose_valid,
  output logic            pose_ready,
  input  cvm_pkg::pose_t  pose,
  output logic            view_valid,
  input  logic            view_ready,
  output cvm_pkg::view_t  view
);

  localparam int LAST = 17;

  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  logic [2:0][15:0]   upv;

  logic               adv;
  cvm_pkg::work_t     st [1:LAST];
  cvm_pkg::work_t     st_next [1:LAST];
  logic [LAST:1]      vld;
  cvm_pkg::view_t     view_next;

  logic               n1_valid;
  cvm_pkg::work_t     n1_pay;
  logic [2:0][15:0]   n1_vec;
  logic               n2_valid;
  cvm_pkg::work_t     n2_pay;
  logic [2:0][15:0]   n2_vec;
  logic [2:0][31:0]   n1_in_vec;

  assign cfg_ready  = 1'b1;
  assign adv        = !view_valid || view_ready;
  assign pose_ready = adv;
  assign upv        = {up_z, up_y, up_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      up_x <= 16'sd0;
      up_y <= 16'sd16384;
      up_z <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cvm_pkg::cfg_reg_t'(cfg_index))
        cvm_pkg::REG_UP_X: up_x <= cfg_data;
        cvm_pkg::REG_UP_Y: up_y <= cfg_data;
        cvm_pkg::REG_UP_Z: up_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sine lanes: 0 sin(yaw), 1 cos(yaw), 2 sin(pitch), 3 cos(pitch).
  always_comb begin
    logic [3:0][15:0]   ang;
    logic [13:0]        frac;
    logic [28:0]        zz;
    logic [24:0]        cz;
    logic [27:0]        zr;
    logic [29:0]        zs;
    logic [15:0]        sw;
    logic signed [31:0] pa;
    logic signed [31:0] pb;
    logic signed [32:0] df;
    logic signed [63:0] pw;
    logic signed [63:0] rd;
    logic signed [47:0] pt;
    int j;
    int k;

    ang = {pose.pitch + 16'd16384, pose.pitch, pose.yaw + 16'd16384, pose.yaw};
    st_next[1] = '0;
    st_next[1].pos = {pose.pos_z, pose.pos_y, pose.pos_x};
    for (int i = 0; i < 4; i++) begin
      frac = ang[i][13:0];
      st_next[1].z[i]   = ang[i][14] ? (15'd16384 - {1'b0, frac}) : {1'b0, frac};
      st_next[1].neg[i] = ang[i][15];
    end

    st_next[2] = st[1];
    for (int i = 0; i < 4; i++) begin
      zz = 29'(st[1].z[i]) * 29'(st[1].z[i]);
      st_next[2].z2[i] = 15'((zz + 29'd8192) >> 14);
    end

    st_next[3] = st[2];
    for (int i = 0; i < 4; i++) begin
      cz = 25'(cvm_pkg::SIN_C) * 25'(st[2].z2[i]);
      st_next[3].r[i] = 15'(cvm_pkg::SIN_B) - 15'((cz + 25'd8192) >> 14);
    end

    st_next[4] = st[3];
    for (int i = 0; i < 4; i++) begin
      zr = 28'(st[3].z2[i]) * 28'(st[3].r[i]);
      st_next[4].r[i] = 15'(cvm_pkg::SIN_A) - 15'((zr + 28'd8192) >> 14);
    end

    st_next[5] = st[4];
    for (int i = 0; i < 4; i++) begin
      zs = 30'(st[4].z[i]) * 30'(st[4].r[i]);
      sw = 16'((zs + 30'd8192) >> 14);
      if (sw > 16'd16384) begin
        sw = 16'd16384;
      end
      st_next[5].sn[i] = st[4].neg[i] ? -sw : sw;
    end

    st_next[6] = st[5];
    pa = $signed(st[5].sn[3]) * $signed(st[5].sn[0]);
    rd = cvm_pkg::round14(64'(pa));
    st_next[6].raw[0] = rd[15:0];
    st_next[6].raw[1] = st[5].sn[2];
    pa = $signed(st[5].sn[3]) * $signed(st[5].sn[1]);
    rd = cvm_pkg::round14(64'(pa));
    st_next[6].raw[2] = rd[15:0];

    st_next[7] = st[6];
    for (int i = 0; i < 3; i++) begin
      pa = $signed(st[6].raw[i]) * $signed(st[6].raw[i]);
      st_next[7].sqp[i] = pa[28:0];
    end

    st_next[8] = st[7];
    st_next[8].sq1 = 30'(st[7].sqp[0]) + 30'(st[7].sqp[1]) + 30'(st[7].sqp[2]);

    st_next[9] = n1_pay;
    st_next[9].f = n1_vec;

    // Cross product forward x up.
    st_next[10] = st[9];
    for (int i = 0; i < 3; i++) begin
      j  = (i == 2) ? 0 : i + 1;
      k  = (i == 0) ? 2 : i - 1;
      pa = $signed(st[9].f[j]) * $signed(upv[k]);
      pb = $signed(st[9].f[k]) * $signed(upv[j]);
      df = 33'(pa) - 33'(pb);
      st_next[10].c[i] = df[31:0];
    end

    st_next[11] = st[10];
    for (int i = 0; i < 3; i++) begin
      pw = $signed(st[10].c[i]) * $signed(st[10].c[i]);
      st_next[11].csq[i] = pw[60:0];
    end

    st_next[12] = st[11];
    st_next[12].sq2 = 62'(st[11].csq[0]) + 62'(st[11].csq[1]) + 62'(st[11].csq[2]);

    st_next[13] = n2_pay;
    st_next[13].s = n2_vec;

    // Cross product side x forward, products first.
    st_next[14] = st[13];
    for (int i = 0; i < 3; i++) begin
      j  = (i == 2) ? 0 : i + 1;
      k  = (i == 0) ? 2 : i - 1;
      pa = $signed(st[13].s[j]) * $signed(st[13].f[k]);
      pb = $signed(st[13].s[k]) * $signed(st[13].f[j]);
      st_next[14].xp[2*i]   = pa;
      st_next[14].xp[2*i+1] = pb;
    end

    st_next[15] = st[14];
    for (int i = 0; i < 3; i++) begin
      df = 33'($signed(st[14].xp[2*i])) - 33'($signed(st[14].xp[2*i+1]));
      rd = cvm_pkg::round14(64'(df));
      if (rd > 64'sd16384) begin
        rd = 64'sd16384;
      end else if (rd < -64'sd16384) begin
        rd = -64'sd16384;
      end
      st_next[15].u[i] = rd[15:0];
    end

    st_next[16] = st[15];
    for (int i = 0; i < 3; i++) begin
      pt = $signed(st[15].s[i]) * $signed(st[15].pos[i]);
      st_next[16].tp[i] = pt;
      pt = $signed(st[15].u[i]) * $signed(st[15].pos[i]);
      st_next[16].tp[3+i] = pt;
      pt = $signed(st[15].f[i]) * $signed(st[15].pos[i]);
      st_next[16].tp[6+i] = pt;
    end

    st_next[17] = st[16];
    for (int i = 0; i < 3; i++) begin
      st_next[17].tsum[i] = 50'($signed(st[16].tp[3*i]))
                          + 50'($signed(st[16].tp[3*i+1]))
                          + 50'($signed(st[16].tp[3*i+2]));
    end
  end

  // Output stage: side and up rows as computed, back row negated, translation rounded, signed and saturated.
  always_comb begin
    logic signed [63:0] rd;
    logic [2:0][31:0]   tr;
    for (int i = 0; i < 3; i++) begin
      rd = cvm_pkg::round14(64'($signed(st[LAST].tsum[i])));
      if (i < 2) begin
        rd = -rd;
      end
      if (rd > 64'sd2147483647) begin
        tr[i] = 32'h7fff_ffff;
      end else if (rd < -64'sd2147483648) begin
        tr[i] = 32'h8000_0000;
      end else begin
        tr[i] = rd[31:0];
      end
    end
    view_next.side_x  = st[LAST].s[0];
    view_next.side_y  = st[LAST].s[1];
    view_next.side_z  = st[LAST].s[2];
    view_next.upv_x   = st[LAST].u[0];
    view_next.upv_y   = st[LAST].u[1];
    view_next.upv_z   = st[LAST].u[2];
    view_next.back_x  = -st[LAST].f[0];
    view_next.back_y  = -st[LAST].f[1];
    view_next.back_z  = -st[LAST].f[2];
    view_next.trans_x = tr[0];
    view_next.trans_y = tr[1];
    view_next.trans_z = tr[2];
  end

  for (genvar g = 0; g < 3; g++) begin : g_n1_vec
    assign n1_in_vec[g] = {{16{st[8].raw[g][15]}}, st[8].raw[g]};
  end

  cvm_normalize #(
    .PW ($bits(cvm_pkg::work_t))
  ) u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vld[8]),
    .in_pay    (st[8]),
    .in_sq     ({32'd0, st[8].sq1}),
    .in_vec    (n1_in_vec),
    .out_valid (n1_valid),
    .out_pay   (n1_pay),
    .out_vec   (n1_vec)
  );

  cvm_normalize #(
    .PW ($bits(cvm_pkg::work_t))
  ) u_norm_side (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vld[12]),
    .in_pay    (st[12]),
    .in_sq     (st[12].sq2),
    .in_vec    (st[12].c),
    .out_valid (n2_valid),
    .out_pay   (n2_pay),
    .out_vec   (n2_vec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      view_valid <= 1'b0;
    end else if (adv) begin
      for (int i = 1; i <= LAST; i++) begin
        if (i == 1) begin
          vld[i] <= pose_valid;
        end else if (i == 9) begin
          vld[i] <= n1_valid;
        end else if (i == 13) begin
          vld[i] <= n2_valid;
        end else begin
          vld[i] <= vld[i-1];
        end
      end
      view_valid <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 1; i <= LAST; i++) begin
        st[i] <= st_next[i];
      end
      view <= view_next;
    end
  end

  `CVM_ASSERT_ALWAYS(a_reset_clears_output, clk, rst |=> !view_valid, "result valid right after reset")
  `CVM_ASSERT(a_degenerate_rows, clk, rst, (view_valid && view.side_x == 16'sd0 && view.side_y == 16'sd0 && view.side_z == 16'sd0) |-> (view.upv_x == 16'sd0 && view.upv_y == 16'sd0 && view.upv_z == 16'sd0 && view.trans_x == 32'sd0 && view.trans_y == 32'sd0), "zero side row with nonzero up row or translation")
  `CVM_ASSERT(a_back_unit_range, clk, rst, view_valid |-> (view.back_x <= 16'sd16384 && view.back_x >= -16'sd16384 && view.back_y <= 16'sd16384 && view.back_y >= -16'sd16384 && view.back_z <= 16'sd16384 && view.back_z >= -16'sd16384), "back row outside unit range")

endmodule

@@ rtl/cvm_sqrt_cell.sv @@
// One step of the bit-serial integer square root chain.
// Uses no package items; instantiated by cvm_normalize.
module cvm_sqrt_cell #(
  parameter int XW     = 62,
  parameter int PW     = 8,
  parameter int BITPOS = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [XW-1:0] in_x,
  input  logic [XW-1:0] in_res,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [XW-1:0] out_x,
  output logic [XW-1:0] out_res,
  output logic [PW-1:0] out_pay
);

  localparam logic [XW-1:0] STEP = XW'(1) << BITPOS;

  logic [XW-1:0] trial;
  logic [XW-1:0] x_next;
  logic [XW-1:0] res_next;

  always_comb begin
    trial = in_res + STEP;
    if (in_x >= trial) begin
      x_next   = in_x - trial;
      res_next = (in_res >> 1) + STEP;
    end else begin
      x_next   = in_x;
      res_next = in_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x   <= x_next;
      out_res <= res_next;
      out_pay <= in_pay;
    end
  end

endmodule

@@ rtl/cvm_div_cell.sv @@
// One quotient bit of a three-lane restoring divider with a shared divisor.
// Uses no package items; instantiated by cvm_normalize.
module cvm_div_cell #(
  parameter int NW = 47,
  parameter int DW = 31,
  parameter int QW = 15,
  parameter int SH = 0,
  parameter int PW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [DW-1:0]        in_den,
  input  logic [2:0][NW-1:0]   in_rem,
  input  logic [2:0][QW-1:0]   in_q,
  input  logic [PW-1:0]        in_pay,
  output logic                 out_valid,
  output logic [DW-1:0]        out_den,
  output logic [2:0][NW-1:0]   out_rem,
  output logic [2:0][QW-1:0]   out_q,
  output logic [PW-1:0]        out_pay
);

  localparam int TW = DW + SH;
  localparam int CW = (NW > TW) ? NW : TW;

  logic [CW-1:0]         trial;
  logic [2:0][NW-1:0]    rem_next;
  logic [2:0][QW-1:0]    q_next;

  always_comb begin
    trial = CW'(in_den) << SH;
    for (int i = 0; i < 3; i++) begin
      if (CW'(in_rem[i]) >= trial) begin
        rem_next[i] = in_rem[i] - NW'(trial);
        q_next[i]   = in_q[i] | (QW'(1) << SH);
      end else begin
        rem_next[i] = in_rem[i];
        q_next[i]   = in_q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_den <= in_den;
      out_rem <= rem_next;
      out_q   <= q_next;
      out_pay <= in_pay;
    end
  end

endmodule

@@ rtl/cvm_normalize.sv @@
// Vector normalizer: square root chain, divider setup and divider chain.
// Depends on cvm_pkg, cvm_sqrt_cell and cvm_div_cell.
module cvm_normalize #(
  parameter int PW = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [PW-1:0]                          in_pay,
  input  logic [2*cvm_pkg::ROOT_W-1:0]           in_sq,
  input  logic [2:0][cvm_pkg::VEC_W-1:0]         in_vec,
  output logic                                   out_valid,
  output logic [PW-1:0]                          out_pay,
  output logic [2:0][15:0]                       out_vec
);

  localparam int RW  = cvm_pkg::ROOT_W;
  localparam int XW  = 2 * RW;
  localparam int VW  = cvm_pkg::VEC_W;
  localparam int NW  = cvm_pkg::NUM_W;
  localparam int QW  = cvm_pkg::QUO_W;
  localparam int SPW = PW + 3 * VW;
  localparam int DPW = PW + 3;

  // Square root chain, one result bit per cell.
  logic [RW:0]            sv;
  logic [RW:0][XW-1:0]    sx;
  logic [RW:0][XW-1:0]    sr;
  logic [RW:0][SPW-1:0]   sp;

  assign sv[0] = in_valid;
  assign sx[0] = in_sq;
  assign sr[0] = '0;
  assign sp[0] = {in_pay, in_vec};

  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    cvm_sqrt_cell #(
      .XW     (XW),
      .PW     (SPW),
      .BITPOS (2 * (RW - 1 - g))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sv[g]),
      .in_x      (sx[g]),
      .in_res    (sr[g]),
      .in_pay    (sp[g]),
      .out_valid (sv[g+1]),
      .out_x     (sx[g+1]),
      .out_res   (sr[g+1]),
      .out_pay   (sp[g+1])
    );
  end

  // Divider setup: magnitudes scaled to Q14 plus half the length for rounding.
  logic [RW-1:0]           root;
  logic [2:0][VW-1:0]      vec;
  logic [2:0][NW-1:0]      num_next;
  logic [2:0]              sign_next;

  logic                    setup_valid;
  logic [RW-1:0]           setup_den;
  logic [2:0][NW-1:0]      setup_num;
  logic [2:0]              setup_sign;
  logic [PW-1:0]           setup_pay;

  assign root = sr[RW][RW-1:0];
  assign vec  = sp[RW][3*VW-1:0];

  always_comb begin
    logic [VW-1:0] mag;
    for (int i = 0; i < 3; i++) begin
      mag          = vec[i][VW-1] ? -vec[i] : vec[i];
      num_next[i]  = (NW'(mag) << 14) + NW'(root >> 1);
      sign_next[i] = vec[i][VW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_valid <= 1'b0;
    end else if (en) begin
      setup_valid <= sv[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      setup_den  <= root;
      setup_num  <= num_next;
      setup_sign <= sign_next;
      setup_pay  <= sp[RW][SPW-1:3*VW];
    end
  end

  // Divider chain, most significant quotient bit first.
  logic [QW:0]                 dv;
  logic [QW:0][RW-1:0]         dd;
  logic [QW:0][2:0][NW-1:0]    drem;
  logic [QW:0][2:0][QW-1:0]    dq;
  logic [QW:0][DPW-1:0]        dp;

  assign dv[0]   = setup_valid;
  assign dd[0]   = setup_den;
  assign drem[0] = setup_num;
  assign dq[0]   = '0;
  assign dp[0]   = {setup_pay, setup_sign};

  for (genvar g = 0; g < QW; g++) begin : g_div
    cvm_div_cell #(
      .NW (NW),
      .DW (RW),
      .QW (QW),
      .SH (QW - 1 - g),
      .PW (DPW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv[g]),
      .in_den    (dd[g]),
      .in_rem    (drem[g]),
      .in_q      (dq[g]),
      .in_pay    (dp[g]),
      .out_valid (dv[g+1]),
      .out_den   (dd[g+1]),
      .out_rem   (drem[g+1]),
      .out_q     (dq[g+1]),
      .out_pay   (dp[g+1])
    );
  end

  assign out_valid = dv[QW];
  assign out_pay   = dp[QW][DPW-1:3];

  // A zero length yields a zero vector.
  always_comb begin
    logic [15:0] qx;
    for (int i = 0; i < 3; i++) begin
      qx = {1'b0, dq[QW][i]};
      if (dd[QW] == '0) begin
        out_vec[i] = '0;
      end else if (dp[QW][i]) begin
        out_vec[i] = -qx;
      end else begin
        out_vec[i] = qx;
      end
    end
  end

endmodule
